// ===== rtl/spw_pkg.sv =====
// Shared types and constants for the stable pose window core.
// Used by every module of the block but spw_ram; depends on nothing.
`timescale 1ns / 1ps

package spw_pkg;

    // Window storage
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int STAMP_W  = 64;
    localparam int POS_W    = 32;
    localparam int HEAD_W   = 16;
    localparam int REQ_W    = 5;
    localparam int PSPAN_W  = 31;
    localparam int YSPAN_W  = 16;
    localparam int FILL_W   = 5;
    localparam int SQ_W     = 2 * POS_W;
    localparam int SUM_W    = SQ_W + 2;

    // Stream and register port widths
    localparam int IN_DATA_W  = STAMP_W + 3 * POS_W + HEAD_W;
    localparam int OUT_DATA_W = 184;
    localparam int USER_W     = 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_REQUIRED = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_SPAN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_YAW_SPAN = 2'd2;

    // Input mode codes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // One stored pose sample
    typedef struct packed {
        logic [HEAD_W-1:0]         heading;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [STAMP_W-1:0] stamp;
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_CHECK,
        S_MM,
        S_WAIT,
        S_YREF,
        S_YCMP,
        S_SQ,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SQ_LIM,
        SQ_X,
        SQ_Y,
        SQ_Z
    } t_sq_sel;

    // Controller to datapath
    typedef struct packed {
        logic              capture;
        logic              update;
        logic              scan_init;
        logic [SLOT_W-1:0] rd_idx;
        logic              mm_acc;
        logic              mm_first;
        logic              yaw_ref;
        logic              yaw_cmp;
        logic              sq_en;
        t_sq_sel           sq_sel;
        logic              result_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             full;
        logic             out_busy;
        logic [CNT_W-1:0] held;
    } t_dp_status;

endpackage

// ===== rtl/spw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spw_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on spw_pkg for widths and register indexes.
`timescale 1ns / 1ps

module spw_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [spw_pkg::CNT_W-1:0]      o_req_eff,
    output logic [spw_pkg::PSPAN_W-1:0]    o_pos_lim,
    output logic [spw_pkg::YSPAN_W-1:0]    o_yaw_lim
);

    import spw_pkg::*;

    logic [REQ_W-1:0]     r_req;
    logic [PSPAN_W-1:0]   r_pos_lim;
    logic [YSPAN_W-1:0]   r_yaw_lim;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req     <= REQ_W'(1);
            r_pos_lim <= PSPAN_W'(65536);
            r_yaw_lim <= YSPAN_W'(1024);
        end else if (wr_en) begin
            case (reg_idx)
                REG_REQUIRED: r_req     <= pwdata[REQ_W-1:0];
                REG_POS_SPAN: r_pos_lim <= pwdata[PSPAN_W-1:0];
                REG_YAW_SPAN: r_yaw_lim <= pwdata[YSPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_REQUIRED: prdata = APB_DATA_W'(r_req);
            REG_POS_SPAN: prdata = APB_DATA_W'(r_pos_lim);
            REG_YAW_SPAN: prdata = APB_DATA_W'(r_yaw_lim);
            default:      prdata = '0;
        endcase
    end

    // Clamp the required count into 1..WINDOW_DEPTH
    always_comb begin
        if (r_req == '0) begin
            o_req_eff = CNT_W'(1);
        end else if (int'(r_req) > WINDOW_DEPTH) begin
            o_req_eff = CNT_W'(WINDOW_DEPTH);
        end else begin
            o_req_eff = CNT_W'(r_req);
        end
    end

    assign o_pos_lim = r_pos_lim;
    assign o_yaw_lim = r_yaw_lim;

endmodule

// ===== rtl/spw_ctrl.sv =====
// Sequencer for one item: update, min/max pass, pairwise heading pass,
// squaring and result hand-off. Depends on spw_pkg.
`timescale 1ns / 1ps

module spw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  spw_pkg::t_dp_status i_status,
    output spw_pkg::t_dp_cmd    o_cmd
);

    import spw_pkg::*;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [SLOT_W-1:0] r_i, n_i;
    t_sq_sel           r_sq, n_sq;
    logic              last_k;
    logic              last_i;

    assign last_k = (CNT_W'(r_k) + CNT_W'(1)) == i_status.held;
    assign last_i = (CNT_W'(r_i) + CNT_W'(2)) == i_status.held;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_sq    <= SQ_LIM;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_sq    <= n_sq;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_i       = r_i;
        n_sq      = r_sq;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.scan_init = 1'b1;
                n_k             = '0;
                n_i             = '0;
                n_sq            = SQ_LIM;
                n_state         = i_status.full ? S_MM : S_DONE;
            end
            // Stream every held sample through the min/max trackers
            S_MM: begin
                o_cmd.rd_idx   = r_k;
                o_cmd.mm_acc   = 1'b1;
                o_cmd.mm_first = (r_k == '0);
                if (last_k) begin
                    n_k     = '0;
                    n_state = (i_status.held == CNT_W'(1)) ? S_WAIT : S_YREF;
                end else begin
                    n_k = r_k + SLOT_W'(1);
                end
            end
            // Let the last bounds reach the span registers before squaring
            S_WAIT: begin
                n_state = S_SQ;
            end
            // Load the reference heading for this row of pairs
            S_YREF: begin
                o_cmd.rd_idx  = r_i;
                o_cmd.yaw_ref = 1'b1;
                n_k           = r_i + SLOT_W'(1);
                n_state       = S_YCMP;
            end
            // Compare the reference against every older sample
            S_YCMP: begin
                o_cmd.rd_idx  = r_k;
                o_cmd.yaw_cmp = 1'b1;
                if (last_k) begin
                    if (last_i) begin
                        n_state = S_SQ;
                    end else begin
                        n_i     = r_i + SLOT_W'(1);
                        n_state = S_YREF;
                    end
                end else begin
                    n_k = r_k + SLOT_W'(1);
                end
            end
            // Square the limit and the three spans on the shared multiplier
            S_SQ: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = r_sq;
                case (r_sq)
                    SQ_LIM:  n_sq = SQ_X;
                    SQ_X:    n_sq = SQ_Y;
                    SQ_Y:    n_sq = SQ_Z;
                    default: n_sq = SQ_LIM;
                endcase
                if (r_sq == SQ_Z) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            // Hold until the result register is free
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spw_dp.sv =====
// Datapath: input capture, window store, min/max and heading trackers,
// shared squaring multiplier and the result register.
// Depends on spw_pkg and spw_ram.
`timescale 1ns / 1ps

module spw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spw_pkg::t_dp_cmd                i_cmd,
    output spw_pkg::t_dp_status             o_status,
    input  logic [spw_pkg::IN_DATA_W-1:0]   i_s_data,
    input  logic [spw_pkg::USER_W-1:0]      i_s_user,
    output logic                            o_m_valid,
    input  logic                            i_m_ready,
    output logic [spw_pkg::OUT_DATA_W-1:0]  o_m_data,
    input  logic [spw_pkg::CNT_W-1:0]       i_req_eff,
    input  logic [spw_pkg::PSPAN_W-1:0]     i_pos_lim,
    input  logic [spw_pkg::YSPAN_W-1:0]     i_yaw_lim
);

    import spw_pkg::*;

    // Wrapped distance between two binary angles
    function automatic logic [HEAD_W-1:0] yaw_dist(input logic [HEAD_W-1:0] a,
                                                   input logic [HEAD_W-1:0] b);
        logic [HEAD_W-1:0] d;
        d = a - b;
        if (d[HEAD_W-1] && (d[HEAD_W-2:0] != '0)) begin
            yaw_dist = -d;
        end else begin
            yaw_dist = d;
        end
    endfunction

    t_sample                   r_in;
    logic                      r_in_mode;
    t_sample                   r_new;
    logic [CNT_W-1:0]          r_held;
    logic [SLOT_W-1:0]         r_slot;
    logic                      r_rej;

    logic [SLOT_W-1:0]         next_slot;
    logic [CNT_W:0]            held_inc;
    logic [CNT_W-1:0]          held_sat;
    logic                      bad_stamp;
    logic                      take;
    logic [SLOT_W-1:0]         rd_slot;
    t_sample                   rd_data;
    logic [SAMPLE_W-1:0]       rd_raw;

    logic                      r_tag_mm;
    logic                      r_tag_first;
    logic                      r_tag_ref;
    logic                      r_tag_cmp;

    logic signed [POS_W-1:0]   r_lo_x, r_hi_x, r_lo_y, r_hi_y, r_lo_z, r_hi_z;
    logic [POS_W-1:0]          r_span_x, r_span_y, r_span_z;
    logic [HEAD_W-1:0]         r_href;
    logic                      r_yaw_fail;

    logic [POS_W-1:0]          sq_op;
    logic [SQ_W-1:0]           r_prod;
    logic                      r_prod_vld;
    logic                      r_prod_lim;
    logic [SQ_W-1:0]           r_lim2;
    logic [SUM_W-1:0]          r_sum;
    logic                      pos_ok;
    logic                      full;
    logic                      ready_res;

    logic                      r_m_valid;
    logic [OUT_DATA_W-1:0]     r_m_data;
    t_sample                   out_s;

    // Stamp test and window bookkeeping
    assign next_slot = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
    assign held_inc  = {1'b0, r_held} + (CNT_W + 1)'(1);
    assign held_sat  = (held_inc > {1'b0, i_req_eff}) ? i_req_eff : held_inc[CNT_W-1:0];
    assign bad_stamp = (r_in.stamp == '0) || r_in.stamp[STAMP_W-1] ||
                       ((r_held != '0) && !(r_in.stamp > r_new.stamp));
    assign take      = i_cmd.update && (r_in_mode == MODE_ADD) && !bad_stamp;
    assign full      = (r_held == i_req_eff);

    // Logical index (0 is newest) to physical slot
    always_comb begin
        if (r_slot >= i_cmd.rd_idx) begin
            rd_slot = r_slot - i_cmd.rd_idx;
        end else begin
            rd_slot = SLOT_W'({1'b0, r_slot} + (SLOT_W + 1)'(WINDOW_DEPTH)
                              - {1'b0, i_cmd.rd_idx});
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in      <= t_sample'(i_s_data);
            r_in_mode <= i_s_user[0];
        end
    end

    // Apply the word to the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_slot <= '0;
            r_rej  <= 1'b0;
        end else if (i_cmd.update) begin
            r_rej <= (r_in_mode == MODE_ADD) && bad_stamp;
            if (r_in_mode == MODE_CLEAR) begin
                r_held <= '0;
            end else if (take) begin
                r_held <= held_sat;
                r_slot <= next_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_new <= r_in;
        end
    end

    spw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (next_slot),
        .i_wdata (r_in),
        .i_raddr (rd_slot),
        .o_rdata (rd_raw)
    );

    assign rd_data = t_sample'(rd_raw);

    // Tag the read so its data is used in the cycle after, when it leaves the RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_mm    <= 1'b0;
            r_tag_first <= 1'b0;
            r_tag_ref   <= 1'b0;
            r_tag_cmp   <= 1'b0;
        end else begin
            r_tag_mm    <= i_cmd.mm_acc;
            r_tag_first <= i_cmd.mm_first;
            r_tag_ref   <= i_cmd.yaw_ref;
            r_tag_cmp   <= i_cmd.yaw_cmp;
        end
    end

    // Track position bounds
    always_ff @(posedge i_clk) begin
        if (r_tag_mm) begin
            if (r_tag_first) begin
                r_lo_x <= rd_data.pos_x;
                r_hi_x <= rd_data.pos_x;
                r_lo_y <= rd_data.pos_y;
                r_hi_y <= rd_data.pos_y;
                r_lo_z <= rd_data.pos_z;
                r_hi_z <= rd_data.pos_z;
            end else begin
                if (rd_data.pos_x < r_lo_x) r_lo_x <= rd_data.pos_x;
                if (rd_data.pos_x > r_hi_x) r_hi_x <= rd_data.pos_x;
                if (rd_data.pos_y < r_lo_y) r_lo_y <= rd_data.pos_y;
                if (rd_data.pos_y > r_hi_y) r_hi_y <= rd_data.pos_y;
                if (rd_data.pos_z < r_lo_z) r_lo_z <= rd_data.pos_z;
                if (rd_data.pos_z > r_hi_z) r_hi_z <= rd_data.pos_z;
            end
        end
        // Span fits 32 bits unsigned, so the wrapped difference is exact
        r_span_x <= POS_W'(r_hi_x - r_lo_x);
        r_span_y <= POS_W'(r_hi_y - r_lo_y);
        r_span_z <= POS_W'(r_hi_z - r_lo_z);
    end

    // Pairwise heading test
    always_ff @(posedge i_clk) begin
        if (r_tag_ref) begin
            r_href <= rd_data.heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_fail <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_yaw_fail <= 1'b0;
        end else if (r_tag_cmp && (yaw_dist(r_href, rd_data.heading) > i_yaw_lim)) begin
            r_yaw_fail <= 1'b1;
        end
    end

    // Shared squaring multiplier
    always_comb begin
        case (i_cmd.sq_sel)
            SQ_LIM:  sq_op = POS_W'(i_pos_lim);
            SQ_X:    sq_op = r_span_x;
            SQ_Y:    sq_op = r_span_y;
            SQ_Z:    sq_op = r_span_z;
            default: sq_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= sq_op * sq_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_prod_lim <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.sq_en;
            r_prod_lim <= (i_cmd.sq_sel == SQ_LIM);
        end
    end

    // Sum of squared spans; no single square can exceed the sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_sum <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_lim) begin
                r_lim2 <= r_prod;
            end else begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end
    end

    assign pos_ok    = (r_sum <= SUM_W'(r_lim2));
    assign ready_res = full && pos_ok && !r_yaw_fail;
    assign out_s     = (r_held != '0) ? r_new : '0;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_m_data <= {1'b0, out_s, FILL_W'(r_held), r_rej, ready_res};
        end
    end

    assign o_m_valid         = r_m_valid;
    assign o_m_data          = r_m_data;
    assign o_status.full     = full;
    assign o_status.out_busy = r_m_valid && !i_m_ready;
    assign o_status.held     = r_held;

endmodule

// ===== rtl/stable_pose_window_core.sv =====
// Top level of the stable pose window: stream ports, register port,
// controller and datapath. Depends on spw_pkg, spw_cfg, spw_ctrl, spw_dp.
`timescale 1ns / 1ps

// Keeps the newest pose samples in a window of required_count entries and
// reports, for every word taken, whether the window is full and stable.
// Words are taken one at a time. An add or clear that leaves the window short
// of required_count goes from the update straight to the result. When the
// window is full, the block walks the stored samples once for the position
// bounds and then compares every pair of headings through the single read
// port of the sample RAM before the squaring. The result register frees the
// input side: a new word is taken while a finished result still waits for
// m_axis_tready.
module stable_pose_window_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: stamp[63:0], pos_x[95:64], pos_y[127:96],
    // pos_z[159:128], heading[175:160]
    input  logic [spw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: mode
    input  logic [spw_pkg::USER_W-1:0]     s_axis_tuser,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata from bit 0: ready_res[0], rejected[1], fill_count[6:2],
    // newest_stamp[70:7], newest_x[102:71], newest_y[134:103],
    // newest_z[166:135], newest_heading[182:167], zero[183]
    output logic [spw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import spw_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [CNT_W-1:0]  req_eff;
    logic [PSPAN_W-1:0] pos_lim;
    logic [YSPAN_W-1:0] yaw_lim;

    spw_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_req_eff (req_eff),
        .o_pos_lim (pos_lim),
        .o_yaw_lim (yaw_lim)
    );

    spw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    spw_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_s_data  (s_axis_tdata),
        .i_s_user  (s_axis_tuser),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .i_req_eff (req_eff),
        .i_pos_lim (pos_lim),
        .i_yaw_lim (yaw_lim)
    );

    // One word in flight: the input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is still in work");

    // A clear empties the window once it has been applied
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_CLEAR)
        |=> ##1 (status.held == '0))
        else $error("clear did not empty the window");

    // An empty window is never ready and shows a zero stamp
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6:2] == '0)
        |-> (m_axis_tdata[0] == 1'b0) && (m_axis_tdata[70:7] == '0))
        else $error("empty window reported ready or a stale sample");

endmodule

// ===== tb/tb_stable_pose_window_core.sv =====
// Self-checking testbench for stable_pose_window_core: directed and random pose words
// are checked against a cycle-free predictor of the window. Depends on spw_pkg and the core.
`timescale 1ns / 1ps

module tb_stable_pose_window_core;
    import spw_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_WORDS   = 128;

    // Expected result word, one per accepted input word
    typedef struct {
        logic              ready_res;
        logic              rejected;
        logic [FILL_W-1:0] fill_count;
        logic [STAMP_W-1:0] newest_stamp;
        logic [POS_W-1:0]  newest_x;
        logic [POS_W-1:0]  newest_y;
        logic [POS_W-1:0]  newest_z;
        logic [HEAD_W-1:0] newest_heading;
    } t_pose_status;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // tdata from bit 0: stamp, pos_x, pos_y, pos_z, heading
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    // tuser from bit 0: mode
    logic [USER_W-1:0]       s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // tdata from bit 0: ready_res, rejected, fill_count, newest_stamp, newest_x,
    // newest_y, newest_z, newest_heading, zero pad
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    stable_pose_window_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predicted window contents and register copies
    logic signed [STAMP_W-1:0] stamp_mem [WINDOW_DEPTH];
    logic signed [POS_W-1:0]   x_mem     [WINDOW_DEPTH];
    logic signed [POS_W-1:0]   y_mem     [WINDOW_DEPTH];
    logic signed [POS_W-1:0]   z_mem     [WINDOW_DEPTH];
    logic [HEAD_W-1:0]         head_mem  [WINDOW_DEPTH];
    int unsigned               win_held;
    int unsigned               win_top;
    logic [REQ_W-1:0]          cfg_req;
    logic [PSPAN_W-1:0]        cfg_pspan;
    logic [YSPAN_W-1:0]        cfg_yspan;

    t_pose_status pending_status_q[$];
    t_pose_status oldest_status;
    int           fail_count;
    int           quiet_cycles;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    // Center of the pose cloud that random samples are drawn around
    logic [POS_W-1:0]  cloud_x;
    logic [POS_W-1:0]  cloud_y;
    logic [POS_W-1:0]  cloud_z;
    logic [HEAD_W-1:0] cloud_head;
    logic              cloud_wide;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned window_goal();
        int unsigned goal;
        goal = 32'(cfg_req);
        if (goal == 0) goal = 1;
        if (goal > WINDOW_DEPTH) goal = WINDOW_DEPTH;
        return goal;
    endfunction

    function automatic int unsigned slot_from_top(int unsigned k);
        return (win_top + WINDOW_DEPTH - (k % WINDOW_DEPTH)) % WINDOW_DEPTH;
    endfunction

    // Max minus min of one position axis over the held samples
    function automatic longint axis_span(int axis);
        longint      lo;
        longint      hi;
        longint      v;
        int unsigned k;
        int unsigned slot;
        lo = 0;
        hi = 0;
        for (k = 0; k < win_held; k++) begin
            slot = slot_from_top(k);
            case (axis)
                0:       v = x_mem[slot];
                1:       v = y_mem[slot];
                default: v = z_mem[slot];
            endcase
            if (k == 0 || v < lo) lo = v;
            if (k == 0 || v > hi) hi = v;
        end
        return hi - lo;
    endfunction

    // Wrapped distance between two binary angles
    function automatic logic [16:0] heading_gap(logic [HEAD_W-1:0] a, logic [HEAD_W-1:0] b);
        logic [HEAD_W-1:0] raw;
        logic [16:0]       gap;
        raw = a - b;
        gap = {1'b0, raw};
        if (gap > 17'd32768) gap = 17'd65536 - gap;
        return gap;
    endfunction

    function automatic logic window_stable();
        logic [SUM_W-1:0] lim2;
        logic [SUM_W-1:0] side;
        logic [SUM_W-1:0] sq_sum;
        int               axis;
        int unsigned      i;
        int unsigned      j;
        if (win_held == 0) return 1'b0;
        lim2   = SUM_W'(cfg_pspan);
        lim2   = lim2 * lim2;
        sq_sum = '0;
        for (axis = 0; axis < 3; axis++) begin
            side = SUM_W'(axis_span(axis));
            side = side * side;
            if (side > lim2) return 1'b0;
            sq_sum = sq_sum + side;
        end
        if (sq_sum > lim2) return 1'b0;
        for (i = 0; i < win_held; i++) begin
            for (j = i + 1; j < win_held; j++) begin
                if (heading_gap(head_mem[slot_from_top(i)], head_mem[slot_from_top(j)])
                        > {1'b0, cfg_yspan})
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the predicted window by one word and return the status it yields
    function automatic t_pose_status predict_pose_status(logic mode, t_sample smp);
        t_pose_status res;
        int unsigned  goal;
        logic         refuse;
        goal   = window_goal();
        refuse = 1'b0;
        if (mode == MODE_CLEAR) begin
            win_held = 0;
        end else begin
            refuse = ($signed(smp.stamp) <= 0);
            if (!refuse && win_held > 0 && $signed(smp.stamp) <= stamp_mem[win_top])
                refuse = 1'b1;
            if (!refuse) begin
                win_top            = (win_top + 1) % WINDOW_DEPTH;
                stamp_mem[win_top] = smp.stamp;
                x_mem[win_top]     = smp.pos_x;
                y_mem[win_top]     = smp.pos_y;
                z_mem[win_top]     = smp.pos_z;
                head_mem[win_top]  = smp.heading;
                win_held           = win_held + 1;
                if (win_held > goal) win_held = goal;
            end
        end
        res.ready_res  = (win_held == goal) && window_stable();
        res.rejected   = refuse;
        res.fill_count = FILL_W'(win_held);
        if (win_held > 0) begin
            res.newest_stamp   = stamp_mem[win_top];
            res.newest_x       = x_mem[win_top];
            res.newest_y       = y_mem[win_top];
            res.newest_z       = z_mem[win_top];
            res.newest_heading = head_mem[win_top];
        end else begin
            res.newest_stamp   = '0;
            res.newest_x       = '0;
            res.newest_y       = '0;
            res.newest_z       = '0;
            res.newest_heading = '0;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Present one word, idling first at the chosen rate; returns at a falling edge
    task automatic send_pose(logic mode, t_sample smp);
        t_pose_status expect_word;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        expect_word      = predict_pose_status(mode, smp);
        pending_status_q = {pending_status_q, expect_word};
        @(negedge i_clk);
    endtask

    task automatic add_pose(logic signed [STAMP_W-1:0] stamp, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                            logic [HEAD_W-1:0] heading);
        t_sample smp;
        smp.stamp   = stamp;
        smp.pos_x   = x;
        smp.pos_y   = y;
        smp.pos_z   = z;
        smp.heading = heading;
        send_pose(MODE_ADD, smp);
    endtask

    // Clear with random payload, which must be ignored
    task automatic clear_window();
        t_sample smp;
        smp = SAMPLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        send_pose(MODE_CLEAR, smp);
    endtask

    // Drop valid, wait for every pending result and let the core go idle
    task automatic settle_window();
        s_axis_tvalid <= 1'b0;
        while (pending_status_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_REQUIRED: cfg_req   = value[REQ_W-1:0];
            REG_POS_SPAN: cfg_pspan = value[PSPAN_W-1:0];
            REG_YAW_SPAN: cfg_yspan = value[YSPAN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned req, int unsigned pspan, int unsigned yspan);
        settle_window();
        write_reg(REG_REQUIRED, req);
        write_reg(REG_POS_SPAN, pspan);
        write_reg(REG_YAW_SPAN, yspan);
    endtask

    // Receiver side: stall at the chosen rate
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------- checker

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status_q.size() == 0) begin
                $error("result word with nothing pending: %h", m_axis_tdata);
                fail_count++;
            end else begin
                oldest_status = pending_status_q[0];
                pending_status_q.delete(0);
                compare_field("ready_res", oldest_status.ready_res, m_axis_tdata[0]);
                compare_field("rejected", oldest_status.rejected, m_axis_tdata[1]);
                compare_field("fill_count", oldest_status.fill_count, m_axis_tdata[6:2]);
                compare_field("newest_stamp", oldest_status.newest_stamp, m_axis_tdata[70:7]);
                compare_field("newest_x", oldest_status.newest_x, m_axis_tdata[102:71]);
                compare_field("newest_y", oldest_status.newest_y, m_axis_tdata[134:103]);
                compare_field("newest_z", oldest_status.newest_z, m_axis_tdata[166:135]);
                compare_field("newest_heading", oldest_status.newest_heading,
                              m_axis_tdata[182:167]);
                compare_field("pad", 64'd0, m_axis_tdata[183]);
            end
        end
    end

    // Watchdog: end the run when no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_stable_pose_window_core: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- random words

    function automatic logic [POS_W-1:0] wobble_pos(logic [POS_W-1:0] reach);
        return $urandom_range(reach, 0) - (reach >> 1);
    endfunction

    function automatic logic [HEAD_W-1:0] wobble_head(logic [16:0] reach);
        logic [31:0] r;
        r = $urandom_range(reach, 0) - (reach >> 1);
        return r[HEAD_W-1:0];
    endfunction

    task automatic renew_cloud();
        cloud_x = $urandom;
        cloud_y = $urandom;
        cloud_z = $urandom;
        if ($urandom_range(99) < 30) cloud_head = HEAD_W'($urandom_range(8)) - 16'd4;
        else cloud_head = HEAD_W'($urandom);
        cloud_wide = ($urandom_range(99) < 30);
    endtask

    // Pose near the cloud center; calm clouds mostly stay within the limits
    function automatic t_sample cloud_pose(logic signed [STAMP_W-1:0] stamp);
        t_sample           smp;
        logic [POS_W-1:0]  pos_reach;
        logic [16:0]       head_reach;
        if (cloud_wide || $urandom_range(99) < 3) pos_reach = {cfg_pspan, 1'b0};
        else pos_reach = {1'b0, cfg_pspan} >> 1;
        if (cloud_wide || $urandom_range(99) < 3) begin
            head_reach = {cfg_yspan, 1'b0};
            if (head_reach > 17'd65535) head_reach = 17'd65535;
        end else begin
            head_reach = {1'b0, cfg_yspan} >> 1;
        end
        smp.stamp   = stamp;
        smp.pos_x   = cloud_x + wobble_pos(pos_reach);
        smp.pos_y   = cloud_y + wobble_pos(pos_reach);
        smp.pos_z   = cloud_z + wobble_pos(pos_reach);
        smp.heading = cloud_head + wobble_head(head_reach);
        return smp;
    endfunction

    task automatic next_random_word(output logic mode, output t_sample smp);
        int unsigned         pick;
        logic [STAMP_W-1:0]  stamp;
        pick = $urandom_range(99);
        mode = MODE_ADD;
        if (pick < 4) begin
            // clear with noise payload, then start a fresh cloud
            mode = MODE_CLEAR;
            smp  = SAMPLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            renew_cloud();
        end else if (pick < 11) begin
            // stamp that must be refused
            case ($urandom_range(3))
                0: stamp = '0;
                1: stamp = {1'b1, 31'($urandom), 32'($urandom)};
                2: stamp = (win_held > 0) ? stamp_mem[win_top] : '0;
                default: stamp = (win_held > 0) ? stamp_mem[win_top] - $urandom_range(1000, 1)
                                                : {1'b1, 63'd0};
            endcase
            smp = cloud_pose(stamp);
        end else if (pick < 16) begin
            // any add word at all
            smp = SAMPLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            // well-formed: strictly newer stamp, or any positive one after a clear
            if (win_held == 0) begin
                stamp     = {$urandom, $urandom};
                stamp[63] = 1'b0;
            end else begin
                stamp = stamp_mem[win_top] + $urandom_range(5000, 1);
            end
            smp = cloud_pose(stamp);
        end
        if ($urandom_range(99) < 2) renew_cloud();
    endtask

    // ---------------------------------------------------------------- tests

    // Reset register values, stamp ordering and clear on a one-sample window
    task automatic test_default_window();
        add_pose(64'sd1, 0, 0, 0, 16'd0);
        add_pose(64'sd0, $urandom, $urandom, $urandom, HEAD_W'($urandom));
        add_pose(64'sh8000_0000_0000_0000, $urandom, $urandom, $urandom, HEAD_W'($urandom));
        add_pose(64'sd1, $urandom, $urandom, $urandom, HEAD_W'($urandom));
        add_pose(64'sh7FFF_FFFF_FFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 16'hFFFF);
        add_pose(64'sh7FFF_FFFF_FFFF_FFFE, $urandom, $urandom, $urandom, HEAD_W'($urandom));
        clear_window();
        clear_window();
    endtask

    // Diagonal exactly at the limit, just over it, and heading wrap across zero
    task automatic test_span_limits();
        set_config(3, 13 * 65536, 10);
        clear_window();
        add_pose(64'sd100, 0, 0, 0, 16'd65530);
        add_pose(64'sd200, 3 * 65536, 4 * 65536, 12 * 65536, 16'd4);
        add_pose(64'sd300, 65536, 65536, 65536, 16'd0);
        add_pose(64'sd350, 0, 0, -1, 16'd2);
        add_pose(64'sd400, 65536, 65536, 65536, 16'd65535);
        add_pose(64'sd400, $urandom, $urandom, $urandom, HEAD_W'($urandom));
    endtask

    // Required count of zero, above the depth, and lowered below the fill
    task automatic test_count_limits();
        int k;
        set_config(0, 32'h7FFF_FFFF, 32768);
        add_pose(64'sd500, 0, 0, 0, 16'd100);
        set_config(31, 32'h7FFF_FFFF, 65535);
        for (k = 0; k < WINDOW_DEPTH; k++)
            add_pose(STAMP_W'(1000 + k), k, -k, k, HEAD_W'($urandom));
        set_config(4, 32'h7FFF_FFFF, 65535);
        add_pose(64'sd0, $urandom, $urandom, $urandom, HEAD_W'($urandom));
        add_pose(64'sd2000, 5, 5, 5, HEAD_W'($urandom));
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        int unsigned req;
        int unsigned pspan;
        int unsigned yspan;
        logic        mode;
        t_sample     smp;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:  begin req = 3;  pspan = 262144;     yspan = 2048;  end
                1:  begin req = 1;  pspan = 1;          yspan = 0;     end
                2:  begin req = 16; pspan = 2147483647; yspan = 65535; end
                3:  begin req = 2;  pspan = 100;        yspan = 1;     end
                4:  begin req = 0;  pspan = 65536;      yspan = 32768; end
                5:  begin req = 4;  pspan = 1073741824; yspan = 512;   end
                6:  begin req = 31; pspan = 5000;       yspan = 32767; end
                7:  begin req = 5;  pspan = 1048576;    yspan = 40000; end
                8:  begin req = 3;  pspan = 2147483647; yspan = 16;    end
                9:  begin req = 8;  pspan = 12345;      yspan = 4096;  end
                10: begin req = 2;  pspan = 2;          yspan = 2;     end
                default: begin req = 16; pspan = 1048576; yspan = 1024; end
            endcase
            // cycle through no idling, sender gaps, receiver stalls, both
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            set_config(req, pspan, yspan);
            renew_cloud();
            for (n = 0; n < PHASE_WORDS; n++) begin
                next_random_word(mode, smp);
                send_pose(mode, smp);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = MODE_ADD;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        win_held       = 0;
        win_top        = 0;
        cfg_req        = 5'd1;
        cfg_pspan      = 31'd65536;
        cfg_yspan      = 16'd1024;
        renew_cloud();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_window();
        test_span_limits();
        test_count_limits();
        test_random_traffic();
        settle_window();

        if (fail_count == 0) begin
            $display("tb_stable_pose_window_core: PASS");
        end else begin
            $display("tb_stable_pose_window_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spw_pkg.sv
rtl/spw_ram.sv
rtl/spw_cfg.sv
rtl/spw_ctrl.sv
rtl/spw_dp.sv
rtl/stable_pose_window_core.sv
tb/tb_stable_pose_window_core.sv
